/* rtl/core/pvts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pvts_pkg
// Shared constants, codes and types of the VM time-slice scheduler.
// ----------------------------------------------------------------------------
package pvts_pkg;

    localparam int MAX_VMS         = 8;
    localparam int PRIO_LEVELS     = 4;
    localparam int SLICE_BITS      = 6;
    localparam int PRIO_FIELD_BITS = 2;

    localparam int IDX_W      = 3;   // vm_index, switch_target, running_vm
    localparam int CMD_W      = 2;
    localparam int CNT_W      = 4;   // vm_count register
    localparam int MASK_W     = 8;
    localparam int PTAB_W     = 16;
    localparam int BTAB_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int PRIO_W     = $clog2(PRIO_LEVELS + 1);

    localparam logic [CMD_W-1:0] CMD_WORK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_IDLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_VM_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIO_TABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET_TAB  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_ENABLE = 3'd4;

    typedef enum logic [1:0] {
        VM_IDLE    = 2'd0,
        VM_READY   = 2'd1,
        VM_RUNNING = 2'd2
    } vm_state_t;

endpackage
`default_nettype wire

/* rtl/core/priority_vm_time_slice_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// priority_vm_time_slice_scheduler
// Preemptive priority scheduler with per-VM time slices for one engine.
// ----------------------------------------------------------------------------
// Each accepted item (work notice, idle notice or tick) updates the VM states
// in its accept cycle, then one compare unit walks the eight VM slots, one a
// cycle, to find the ready enabled VM with the lowest priority number. A
// decide cycle checks the switch conditions and, when they hold, a switch
// cycle starts the chosen VM. The result is registered into the output in
// the done state once the output holds no stalled result; a fast-path start,
// a tick while ticks are disabled and an unused command skip the pass and go
// straight to the done state. s_ready is high only between items;
// configuration writes are always taken (cfg_ready is tied high).
// ----------------------------------------------------------------------------
module priority_vm_time_slice_scheduler (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pvts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pvts_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [pvts_pkg::CMD_W-1:0]          s_cmd,
    input  wire logic [pvts_pkg::IDX_W-1:0]          s_vm_index,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_switched,
    output logic [pvts_pkg::IDX_W-1:0]               m_switch_target,
    output logic                                     m_engine_busy,
    output logic [pvts_pkg::IDX_W-1:0]               m_running_vm,
    output logic                                     m_rejected
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SWITCH = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    localparam int IDX_W  = pvts_pkg::IDX_W;
    localparam int CNT_W  = pvts_pkg::CNT_W;
    localparam int PRIO_W = pvts_pkg::PRIO_W;
    localparam int SB     = pvts_pkg::SLICE_BITS;
    localparam logic [SB-1:0]     SLICE_MAX = {SB{1'b1}};
    localparam logic [PRIO_W-1:0] PRIO_MAX  = PRIO_W'(pvts_pkg::PRIO_LEVELS - 1);
    localparam logic [PRIO_W-1:0] PRIO_NONE = PRIO_W'(pvts_pkg::PRIO_LEVELS);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(pvts_pkg::MAX_VMS);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(pvts_pkg::MAX_VMS - 1);

    // configuration
    logic [CNT_W-1:0]              cfg_count_reg;
    logic [pvts_pkg::MASK_W-1:0]   cfg_enable_reg;
    logic [pvts_pkg::PTAB_W-1:0]   cfg_prio_reg;
    logic [pvts_pkg::BTAB_W-1:0]   cfg_budget_reg;
    logic                          cfg_tick_en_reg;

    // scheduler state
    pvts_pkg::vm_state_t vm_state_reg [pvts_pkg::MAX_VMS];
    state_t              state_reg, state_next;
    logic                have_active_reg, have_active_next;
    logic [IDX_W-1:0]    active_slot_reg, active_slot_next;
    logic [SB-1:0]       slice_ticks_reg, slice_ticks_next;

    // scan unit
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PRIO_W-1:0]   lead_prio_reg, lead_prio_next;
    logic [IDX_W-1:0]    best_reg, best_next;
    logic                found_reg, found_next;

    // per-item result
    logic                switched_reg, switched_next;
    logic [IDX_W-1:0]    target_reg, target_next;
    logic                rejected_reg, rejected_next;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic                m_switched_reg;
    logic [IDX_W-1:0]    m_target_reg;
    logic                m_busy_reg;
    logic [IDX_W-1:0]    m_running_reg;
    logic                m_rejected_reg;
    logic                out_load;

    // state table write port
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    pvts_pkg::vm_state_t wr_data;

    // single read port onto per-VM state and config fields
    logic [IDX_W-1:0]                         rd_addr;
    pvts_pkg::vm_state_t                      rd_state;
    logic                                     rd_enabled;
    logic [pvts_pkg::PRIO_FIELD_BITS-1:0]     rd_prio_raw;
    logic [PRIO_W-1:0]                        rd_prio;
    logic [SB-1:0]                            rd_budget;

    logic [CNT_W-1:0]    eff_count;
    logic                in_range;
    logic                scan_hit;
    logic                prio_lt;
    logic                go;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    assign eff_count = (cfg_count_reg > CNT_MAX) ? CNT_MAX : cfg_count_reg;
    assign in_range  = {1'b0, s_vm_index} < eff_count;

    always_comb begin
        unique case (state_reg)
            S_IDLE:  rd_addr = (s_cmd == pvts_pkg::CMD_TICK) ? active_slot_reg : s_vm_index;
            S_SCAN:  rd_addr = idx_reg;
            default: rd_addr = active_slot_reg;
        endcase
    end

    assign rd_state    = vm_state_reg[rd_addr];
    assign rd_enabled  = cfg_enable_reg[rd_addr];
    assign rd_prio_raw = cfg_prio_reg[rd_addr * pvts_pkg::PRIO_FIELD_BITS +:
                                      pvts_pkg::PRIO_FIELD_BITS];
    assign rd_prio     = (PRIO_W'(rd_prio_raw) > PRIO_MAX) ? PRIO_MAX : PRIO_W'(rd_prio_raw);
    assign rd_budget   = cfg_budget_reg[rd_addr * SB +: SB];

    // shared priority comparator: scan asks slot < best, decide asks best < active
    assign prio_lt = (state_reg == S_SCAN) ? (rd_prio < lead_prio_reg)
                                           : (lead_prio_reg < rd_prio);

    assign scan_hit = ({1'b0, idx_reg} < eff_count) && rd_enabled &&
                      (rd_state == pvts_pkg::VM_READY) && prio_lt;

    assign go = found_reg &&
                (!have_active_reg || prio_lt || (rd_state != pvts_pkg::VM_RUNNING) ||
                 ((rd_budget != '0) && (slice_ticks_reg >= rd_budget)));

    always_comb begin
        state_next       = state_reg;
        have_active_next = have_active_reg;
        active_slot_next = active_slot_reg;
        slice_ticks_next = slice_ticks_reg;
        idx_next         = idx_reg;
        lead_prio_next   = lead_prio_reg;
        best_next        = best_reg;
        found_next       = found_reg;
        switched_next    = switched_reg;
        target_next      = target_reg;
        rejected_next    = rejected_reg;
        wr_en            = 1'b0;
        wr_addr          = s_vm_index;
        wr_data          = pvts_pkg::VM_READY;
        out_load         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    switched_next  = 1'b0;
                    target_next    = '0;
                    rejected_next  = 1'b0;
                    idx_next       = '0;
                    lead_prio_next = PRIO_NONE;
                    best_next      = '0;
                    found_next     = 1'b0;
                    state_next     = S_DONE;
                    unique case (s_cmd)
                        pvts_pkg::CMD_WORK: begin
                            state_next = S_SCAN;
                            if (in_range && rd_state == pvts_pkg::VM_IDLE) begin
                                wr_en = 1'b1;
                                if (!have_active_reg) begin
                                    if (rd_enabled) begin
                                        // fast path: start at once, skip the pass
                                        wr_data          = pvts_pkg::VM_RUNNING;
                                        have_active_next = 1'b1;
                                        active_slot_next = s_vm_index;
                                        slice_ticks_next = '0;
                                        switched_next    = 1'b1;
                                        target_next      = s_vm_index;
                                        state_next       = S_DONE;
                                    end else begin
                                        rejected_next = 1'b1;
                                    end
                                end
                            end
                        end
                        pvts_pkg::CMD_IDLE: begin
                            state_next = S_SCAN;
                            if (in_range && rd_state == pvts_pkg::VM_RUNNING) begin
                                wr_en   = 1'b1;
                                wr_data = pvts_pkg::VM_IDLE;
                            end
                        end
                        pvts_pkg::CMD_TICK: begin
                            if (cfg_tick_en_reg) begin
                                state_next = S_SCAN;
                                if (have_active_reg && rd_state == pvts_pkg::VM_RUNNING &&
                                    slice_ticks_reg != SLICE_MAX) begin
                                    slice_ticks_next = slice_ticks_reg + 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    lead_prio_next = rd_prio;
                    best_next      = idx_reg;
                    found_next     = 1'b1;
                end
                if (idx_reg == IDX_LAST) begin
                    state_next = S_DECIDE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DECIDE: begin
                if (go) begin
                    // return the old VM to ready if it is still running
                    if (have_active_reg && rd_state == pvts_pkg::VM_RUNNING) begin
                        wr_en   = 1'b1;
                        wr_addr = active_slot_reg;
                        wr_data = pvts_pkg::VM_READY;
                    end
                    state_next = S_SWITCH;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SWITCH: begin
                wr_en            = 1'b1;
                wr_addr          = best_reg;
                wr_data          = pvts_pkg::VM_RUNNING;
                have_active_next = 1'b1;
                active_slot_next = best_reg;
                slice_ticks_next = '0;
                switched_next    = 1'b1;
                target_next      = best_reg;
                state_next       = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_count_reg   <= CNT_MAX;
            cfg_enable_reg  <= '0;
            cfg_prio_reg    <= '0;
            cfg_budget_reg  <= '0;
            cfg_tick_en_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pvts_pkg::REG_VM_COUNT:    cfg_count_reg   <= cfg_data[CNT_W-1:0];
                pvts_pkg::REG_ENABLE_MASK: cfg_enable_reg  <= cfg_data[pvts_pkg::MASK_W-1:0];
                pvts_pkg::REG_PRIO_TABLE:  cfg_prio_reg    <= cfg_data[pvts_pkg::PTAB_W-1:0];
                pvts_pkg::REG_BUDGET_TAB:  cfg_budget_reg  <= cfg_data[pvts_pkg::BTAB_W-1:0];
                pvts_pkg::REG_TICK_ENABLE: cfg_tick_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pvts_pkg::MAX_VMS; i++) begin
                vm_state_reg[i] <= pvts_pkg::VM_IDLE;
            end
            state_reg       <= S_IDLE;
            have_active_reg <= 1'b0;
            active_slot_reg <= '0;
            slice_ticks_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (wr_en) begin
                vm_state_reg[wr_addr] <= wr_data;
            end
            state_reg       <= state_next;
            have_active_reg <= have_active_next;
            active_slot_reg <= active_slot_next;
            slice_ticks_reg <= slice_ticks_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        lead_prio_reg <= lead_prio_next;
        best_reg      <= best_next;
        found_reg     <= found_next;
        switched_reg  <= switched_next;
        target_reg    <= target_next;
        rejected_reg  <= rejected_next;
        if (out_load) begin
            m_switched_reg <= switched_reg;
            m_target_reg   <= target_reg;
            m_busy_reg     <= have_active_reg;
            m_running_reg  <= have_active_reg ? active_slot_reg : '0;
            m_rejected_reg <= rejected_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_switched      = m_switched_reg;
    assign m_switch_target = m_target_reg;
    assign m_engine_busy   = m_busy_reg;
    assign m_running_vm    = m_running_reg;
    assign m_rejected      = m_rejected_reg;

endmodule
`default_nettype wire

/* rtl/core/pvts_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pvts_checker
// Port-level assertions for the VM time-slice scheduler, bound to the top.
// ----------------------------------------------------------------------------
module pvts_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic                             m_switched,
    input wire logic [pvts_pkg::IDX_W-1:0]       m_switch_target,
    input wire logic                             m_engine_busy,
    input wire logic [pvts_pkg::IDX_W-1:0]       m_running_vm,
    input wire logic                             m_rejected
);

    // one item at a time: ready drops right after an item is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready stayed high after an accepted item");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_switched) &&
                                $stable(m_switch_target) && $stable(m_running_vm) &&
                                $stable(m_engine_busy) && $stable(m_rejected))
        else $error("stalled result changed");

    a_idle_engine: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_engine_busy |-> m_running_vm == '0 && !m_switched)
        else $error("running_vm or switched set with engine free");

    a_switch_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_switched |-> m_engine_busy && m_running_vm == m_switch_target)
        else $error("switch target is not the running VM");

endmodule

bind priority_vm_time_slice_scheduler pvts_checker u_pvts_checker (.*);
`default_nettype wire
